FILE: rtl/swgd_pkg.sv
// Shared types and constants for the swipe gesture direction detector.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package swgd_pkg;

    // sample and direction widths
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned DIR_W    = LEVEL_W + 1;   // r - l or u - d
    localparam int unsigned DELTA_W  = DIR_W + 1;     // entry - last
    localparam int unsigned MARGIN_W = 7;
    localparam int unsigned GEST_W   = 3;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ABSENCE_THRESHOLD  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SENSITIVITY_MARGIN = 1'd1;

    // register reset values
    localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET = 8'd30;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET    = 7'd20;

    // stream widths (whole bytes)
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    // gesture codes
    typedef enum logic [GEST_W-1:0] {
        GEST_NONE  = 3'd0,
        GEST_UP    = 3'd1,
        GEST_DOWN  = 3'd2,
        GEST_LEFT  = 3'd3,
        GEST_RIGHT = 3'd4
    } gesture_t;

    // live configuration
    typedef struct packed {
        logic [LEVEL_W-1:0]  threshold;
        logic [MARGIN_W-1:0] margin;
    } cfg_t;

    // one proximity sample
    typedef struct packed {
        logic               clear_latch;
        logic [LEVEL_W-1:0] right_level;
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] down_level;
        logic [LEVEL_W-1:0] up_level;
    } sample_t;

    // one result
    typedef struct packed {
        gesture_t pending_gesture;
        gesture_t gesture_now;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/swgd_cfg.sv
// Configuration registers: absence threshold and sensitivity margin.
// Depends on swgd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swgd_cfg
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [swgd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [swgd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output swgd_pkg::cfg_t                        cfg
);
    import swgd_pkg::*;

    logic [LEVEL_W-1:0]  threshold_reg;
    logic [MARGIN_W-1:0] margin_reg;

    // register writes, masked to register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            margin_reg    <= MARGIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ABSENCE_THRESHOLD:  threshold_reg <= cfg_wdata[LEVEL_W-1:0];
                REG_SENSITIVITY_MARGIN: margin_reg    <= cfg_wdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.threshold = threshold_reg;
    assign cfg.margin    = margin_reg;

endmodule

`default_nettype wire

FILE: rtl/swgd_core.sv
// Per-sample decision logic and the tracking state (armed flag, last and
// entry direction vectors, latched gesture). Depends on swgd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swgd_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  swgd_pkg::sample_t       sample,
    input  swgd_pkg::cfg_t          cfg,
    output swgd_pkg::result_t       result
);
    import swgd_pkg::*;

    logic                       armed_reg, armed_next;
    logic signed [DIR_W-1:0]    last_x_reg, last_x_next;
    logic signed [DIR_W-1:0]    last_y_reg, last_y_next;
    logic signed [DIR_W-1:0]    entry_x_reg, entry_x_next;
    logic signed [DIR_W-1:0]    entry_y_reg, entry_y_next;
    gesture_t                   latch_reg, latch_next;

    logic                       absent;
    logic                       has_entry;
    logic signed [DIR_W-1:0]    dir_x;
    logic signed [DIR_W-1:0]    dir_y;
    logic signed [DELTA_W-1:0]  delta_x;
    logic signed [DELTA_W-1:0]  delta_y;
    logic signed [DELTA_W-1:0]  pos_margin;
    logic signed [DELTA_W-1:0]  neg_margin;
    gesture_t                   now;
    gesture_t                   pending;

    // presence test and current direction
    assign absent = (sample.up_level    < cfg.threshold) &&
                    (sample.down_level  < cfg.threshold) &&
                    (sample.left_level  < cfg.threshold) &&
                    (sample.right_level < cfg.threshold);
    assign dir_x = $signed({1'b0, sample.right_level}) - $signed({1'b0, sample.left_level});
    assign dir_y = $signed({1'b0, sample.up_level})    - $signed({1'b0, sample.down_level});

    // net motion from entry to last sample
    assign has_entry  = (entry_x_reg != '0) || (entry_y_reg != '0);
    assign delta_x    = DELTA_W'(entry_x_reg) - DELTA_W'(last_x_reg);
    assign delta_y    = DELTA_W'(entry_y_reg) - DELTA_W'(last_y_reg);
    assign pos_margin = $signed({{(DELTA_W-MARGIN_W){1'b0}}, cfg.margin});
    assign neg_margin = -pos_margin;

    // direction decision, later tests win
    always_comb
    begin
        now = GEST_NONE;
        if (absent && has_entry)
        begin
            if (delta_x < neg_margin) now = GEST_LEFT;
            if (delta_x > pos_margin) now = GEST_RIGHT;
            if (delta_y < neg_margin) now = GEST_DOWN;
            if (delta_y > pos_margin) now = GEST_UP;
        end
    end

    assign pending = (now != GEST_NONE) ? now : latch_reg;

    // next tracking state
    always_comb
    begin
        armed_next   = armed_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        entry_x_next = entry_x_reg;
        entry_y_next = entry_y_reg;
        latch_next   = sample.clear_latch ? GEST_NONE : pending;
        if (absent)
        begin
            armed_next = 1'b1;
            if (has_entry)
            begin
                last_x_next  = '0;
                last_y_next  = '0;
                entry_x_next = '0;
                entry_y_next = '0;
            end
        end
        else
        begin
            last_x_next = dir_x;
            last_y_next = dir_y;
            if (armed_reg)
            begin
                armed_next   = 1'b0;
                entry_x_next = dir_x;
                entry_y_next = dir_y;
            end
        end
    end

    // state update once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            entry_x_reg <= '0;
            entry_y_reg <= '0;
            latch_reg   <= GEST_NONE;
        end
        else if (step)
        begin
            armed_reg   <= armed_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
            entry_x_reg <= entry_x_next;
            entry_y_reg <= entry_y_next;
            latch_reg   <= latch_next;
        end
    end

    assign result.gesture_now     = now;
    assign result.pending_gesture = pending;

endmodule

`default_nettype wire

FILE: rtl/swipe_gesture_direction_detector.sv
// Swipe gesture direction detector: one result transfer per sample transfer,
// in order. A sample is registered at the input, decided from the input
// register and placed in the result register; a new sample is taken every
// cycle while results drain, and throughput is one sample per cycle while
// the result register is free or being taken. When the result register is
// full and not being taken, the input register fills and s_axis_tready
// drops. Configuration writes take effect for samples decided after the
// write. Depends on swgd_pkg, swgd_cfg and swgd_core.
`timescale 1ns / 1ps
`default_nettype none

module swipe_gesture_direction_detector
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [swgd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [swgd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // samples
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // up_level[7:0], down_level[15:8], left_level[23:16], right_level[31:24],
    // clear_latch[32], zero[39:33]
    input  wire logic [swgd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // results
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // gesture_now[2:0], pending_gesture[5:3], zero[7:6]
    output logic [swgd_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import swgd_pkg::*;

    cfg_t    cfg;
    sample_t sample_reg;
    logic    sample_valid_reg;
    result_t result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    out_free;
    logic    advance;
    logic    s_xfer;

    swgd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // pipeline handshake
    assign out_free      = !result_valid_reg || m_axis_tready;
    assign advance       = sample_valid_reg && out_free;
    assign s_axis_tready = !sample_valid_reg || out_free;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            sample_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            sample_reg.up_level    <= s_axis_tdata[7:0];
            sample_reg.down_level  <= s_axis_tdata[15:8];
            sample_reg.left_level  <= s_axis_tdata[23:16];
            sample_reg.right_level <= s_axis_tdata[31:24];
            sample_reg.clear_latch <= s_axis_tdata[32];
        end
    end

    swgd_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (sample_reg),
        .cfg    (cfg),
        .result (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= sample_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = result_valid_reg;
    assign m_axis_tdata  = {2'b00, result_reg.pending_gesture, result_reg.gesture_now};

    // a gesture decided by a sample is also the one reported as pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (result_reg.gesture_now != GEST_NONE))
            |-> (result_reg.pending_gesture == result_reg.gesture_now))
        else $error("decided gesture differs from pending gesture");

    // input back-pressure only while a held sample waits on a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (sample_valid_reg && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a stalled result");

    // a sample held in the input register moves to the output once it frees
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("advanced sample produced no result");

endmodule

`default_nettype wire

FILE: sim/swipe_gesture_direction_detector_tb.sv
// Self-checking testbench for the swipe gesture direction detector.
// Drives sample transfers, predicts every result and checks each result transfer.
// Depends on swgd_pkg and the swipe_gesture_direction_detector top level.
`timescale 1ns / 1ps

module swipe_gesture_direction_detector_tb;

    import swgd_pkg::*;

    // run limits
    localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no transfer at all
    localparam int unsigned LONG_HOLD     = 300;   // receiver hold-off
    localparam int unsigned DRAIN_CYCLES  = 8;     // drain margin after the last result
    localparam int unsigned PHASE_ITEMS   = 150;
    localparam int unsigned PHASE_COUNT   = 7;
    localparam int unsigned DIRECTED_ROWS = 28;

    // directed rows either carry a typed result or use the predictor
    localparam logic CHK  = 1'b1;
    localparam logic PRED = 1'b0;

    typedef struct packed {
        logic [LEVEL_W-1:0] up;
        logic [LEVEL_W-1:0] down;
        logic [LEVEL_W-1:0] left;
        logic [LEVEL_W-1:0] right;
        logic               clr;
        logic               typed;
        gesture_t           now_g;
        gesture_t           pend_g;
    } stim_row_t;

    // default thresholds: 30 absence, 20 margin
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // absence right after reset only arms
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, CHK,  GEST_NONE,  GEST_NONE},
        '{8'd255, 8'd0,   8'd0,   8'd0,   1'b0, CHK,  GEST_NONE,  GEST_NONE},
        '{8'd0,   8'd255, 8'd0,   8'd0,   1'b0, CHK,  GEST_NONE,  GEST_NONE},
        // just below threshold counts as dark
        '{8'd29,  8'd29,  8'd29,  8'd29,  1'b0, CHK,  GEST_UP,    GEST_UP},
        // zero entry vector, clear the latch
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, CHK,  GEST_NONE,  GEST_UP},
        '{8'd0,   8'd255, 8'd0,   8'd0,   1'b0, CHK,  GEST_NONE,  GEST_NONE},
        '{8'd255, 8'd0,   8'd0,   8'd0,   1'b0, CHK,  GEST_NONE,  GEST_NONE},
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, CHK,  GEST_DOWN,  GEST_DOWN},
        '{8'd0,   8'd0,   8'd255, 8'd0,   1'b0, PRED, GEST_NONE,  GEST_NONE},
        '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0, PRED, GEST_NONE,  GEST_NONE},
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, CHK,  GEST_LEFT,  GEST_LEFT},
        '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0, PRED, GEST_NONE,  GEST_NONE},
        '{8'd0,   8'd0,   8'd255, 8'd0,   1'b0, PRED, GEST_NONE,  GEST_NONE},
        // decision and clear in the same transfer
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, CHK,  GEST_RIGHT, GEST_RIGHT},
        // vertical wins over horizontal
        '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, PRED, GEST_NONE,  GEST_NONE},
        '{8'd0,   8'd255, 8'd255, 8'd0,   1'b0, PRED, GEST_NONE,  GEST_NONE},
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, CHK,  GEST_UP,    GEST_UP},
        '{8'd0,   8'd255, 8'd255, 8'd0,   1'b0, PRED, GEST_NONE,  GEST_NONE},
        '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, PRED, GEST_NONE,  GEST_NONE},
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, CHK,  GEST_DOWN,  GEST_DOWN},
        // motion equal to the margin decides nothing, latch holds
        '{8'd100, 8'd90,  8'd0,   8'd0,   1'b0, PRED, GEST_NONE,  GEST_NONE},
        '{8'd90,  8'd100, 8'd0,   8'd0,   1'b0, PRED, GEST_NONE,  GEST_NONE},
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, PRED, GEST_NONE,  GEST_NONE},
        // one above the margin decides
        '{8'd100, 8'd89,  8'd0,   8'd0,   1'b0, PRED, GEST_NONE,  GEST_NONE},
        '{8'd90,  8'd100, 8'd0,   8'd0,   1'b0, PRED, GEST_NONE,  GEST_NONE},
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, PRED, GEST_NONE,  GEST_NONE},
        // balanced full-scale entry leaves a zero entry vector
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, PRED, GEST_NONE,  GEST_NONE},
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, PRED, GEST_NONE,  GEST_NONE}
    };

    // dut signals; the driven inputs are known from time zero
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_ABSENCE_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // predicted detector state and configuration
    logic                    armed_q;
    logic signed [DIR_W-1:0] last_x_q;
    logic signed [DIR_W-1:0] last_y_q;
    logic signed [DIR_W-1:0] entry_x_q;
    logic signed [DIR_W-1:0] entry_y_q;
    gesture_t                latch_q;
    logic [LEVEL_W-1:0]      threshold_q;
    logic [MARGIN_W-1:0]     margin_q;

    result_t     expected_gestures [$];
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned burst_left = 0;
    logic        hold_request = 1'b0;

    swipe_gesture_direction_detector u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 100 MHz clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // advance the predicted state by one sample and return its result
    task automatic compute_gesture(input sample_t smp, output result_t res);
        int       tx;
        int       ty;
        int       m;
        gesture_t now_g;
        now_g = GEST_NONE;
        m = int'(margin_q);
        if (smp.up_level < threshold_q && smp.down_level < threshold_q &&
            smp.left_level < threshold_q && smp.right_level < threshold_q)
        begin
            armed_q = 1'b1;
            if (entry_x_q != 0 || entry_y_q != 0)
            begin
                tx = int'(entry_x_q) - int'(last_x_q);
                ty = int'(entry_y_q) - int'(last_y_q);
                // later tests override earlier ones
                if (tx < -m) now_g = GEST_LEFT;
                if (tx > m)  now_g = GEST_RIGHT;
                if (ty < -m) now_g = GEST_DOWN;
                if (ty > m)  now_g = GEST_UP;
                if (now_g != GEST_NONE) latch_q = now_g;
                last_x_q = '0;
                last_y_q = '0;
                entry_x_q = '0;
                entry_y_q = '0;
            end
        end
        else
        begin
            last_x_q = {1'b0, smp.right_level} - {1'b0, smp.left_level};
            last_y_q = {1'b0, smp.up_level} - {1'b0, smp.down_level};
            if (armed_q)
            begin
                armed_q = 1'b0;
                entry_x_q = last_x_q;
                entry_y_q = last_y_q;
            end
        end
        res.gesture_now = now_g;
        res.pending_gesture = latch_q;
        if (smp.clear_latch) latch_q = GEST_NONE;
    endtask

    // offer one sample in bursts with random gaps, queue its expected result
    task automatic send_sample(input sample_t smp, input logic typed,
                               input gesture_t now_g, input gesture_t pend_g);
        int unsigned gap;
        result_t     res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - $bits(sample_t)){1'b0}}, smp};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        compute_gesture(smp, res);
        if (typed)
        begin
            res.gesture_now = now_g;
            res.pending_gesture = pend_g;
        end
        expected_gestures.push_back(res);
    endtask

    // wait for all results, let the pipeline settle, then write both registers
    task automatic set_config(input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] margin);
        s_axis_tvalid <= 1'b0;
        while (expected_gestures.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ABSENCE_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge clk);
        cfg_index <= REG_SENSITIVITY_MARGIN;
        cfg_wdata <= margin;
        @(posedge clk);
        cfg_we <= 1'b0;
        threshold_q = thr;
        margin_q = margin[MARGIN_W-1:0];
    endtask

    // all four channels dark when the threshold is nonzero
    function automatic sample_t dark_sample();
        sample_t smp;
        smp = sample_t'({$urandom, $urandom});
        if (threshold_q != 0)
        begin
            smp.up_level    = LEVEL_W'($urandom_range(0, threshold_q - 1));
            smp.down_level  = LEVEL_W'($urandom_range(0, threshold_q - 1));
            smp.left_level  = LEVEL_W'($urandom_range(0, threshold_q - 1));
            smp.right_level = LEVEL_W'($urandom_range(0, threshold_q - 1));
        end
        smp.clear_latch = ($urandom_range(0, 3) == 0);
        return smp;
    endfunction

    // at least one channel lit
    function automatic sample_t lit_sample();
        sample_t smp;
        smp = sample_t'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: smp.up_level    = LEVEL_W'($urandom_range(threshold_q, 255));
            1: smp.down_level  = LEVEL_W'($urandom_range(threshold_q, 255));
            2: smp.left_level  = LEVEL_W'($urandom_range(threshold_q, 255));
            default: smp.right_level = LEVEL_W'($urandom_range(threshold_q, 255));
        endcase
        smp.clear_latch = ($urandom_range(0, 3) == 0);
        return smp;
    endfunction

    // main stimulus
    initial
    begin
        sample_t     smp;
        int unsigned sent;
        int unsigned runs;
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] margin;

        armed_q = 1'b0;
        last_x_q = '0;
        last_y_q = '0;
        entry_x_q = '0;
        entry_y_q = '0;
        latch_q = GEST_NONE;
        threshold_q = THRESHOLD_RESET;
        margin_q = MARGIN_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset configuration
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            smp.up_level    = directed_rows[i].up;
            smp.down_level  = directed_rows[i].down;
            smp.left_level  = directed_rows[i].left;
            smp.right_level = directed_rows[i].right;
            smp.clear_latch = directed_rows[i].clr;
            send_sample(smp, directed_rows[i].typed, directed_rows[i].now_g,
                        directed_rows[i].pend_g);
        end

        // random phases, extremes of both registers first
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin thr = 8'd0;   margin = 8'd0;   end
                1: begin thr = 8'd255; margin = 8'd100; end
                2: begin thr = 8'd30;  margin = 8'hFF;  end
                3: begin thr = 8'd128; margin = 8'd101; end
                default:
                begin
                    thr = CFG_DATA_W'($urandom_range(1, 254));
                    margin = CFG_DATA_W'($urandom_range(0, 255));
                end
            endcase
            set_config(thr, margin);
            if (p == 1 || p == 4) hold_request = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    // well-formed swipe: dark, lit run, dark
                    runs = $urandom_range(1, 2);
                    repeat (runs) send_sample(dark_sample(), PRED, GEST_NONE, GEST_NONE);
                    sent += runs;
                    runs = $urandom_range(1, 5);
                    repeat (runs) send_sample(lit_sample(), PRED, GEST_NONE, GEST_NONE);
                    sent += runs;
                    send_sample(dark_sample(), PRED, GEST_NONE, GEST_NONE);
                    sent++;
                end
                else
                begin
                    // noise
                    runs = $urandom_range(1, 3);
                    repeat (runs)
                    begin
                        smp = sample_t'({$urandom, $urandom});
                        send_sample(smp, PRED, GEST_NONE, GEST_NONE);
                    end
                    sent += runs;
                end
            end
        end

        // drain and report
        s_axis_tvalid <= 1'b0;
        while (expected_gestures.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // receiver: stall patterns in segments, long hold-off on request
    initial
    begin
        int unsigned mode;
        int unsigned seg;
        int unsigned tick;
        logic        ready;
        tick = 0;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            seg = $urandom_range(10, 60);
            repeat (seg)
            begin
                case (mode)
                    0: ready = 1'b1;
                    1: ready = ($urandom_range(0, 3) != 0);
                    2: ready = 1'($urandom_range(0, 1));
                    default: ready = (tick % 3) != 0;
                endcase
                tick++;
                m_axis_tready <= ready;
                @(posedge clk);
            end
        end
    end

    // check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        result_t got;
        result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
            if (expected_gestures.size() == 0)
            begin
                $error("result transfer with nothing expected: tdata %0h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                exp_r = expected_gestures.pop_front();
                if (got.gesture_now !== exp_r.gesture_now)
                begin
                    $error("gesture_now mismatch: expected %0d, actual %0d",
                           exp_r.gesture_now, got.gesture_now);
                    error_count++;
                end
                if (got.pending_gesture !== exp_r.pending_gesture)
                begin
                    $error("pending_gesture mismatch: expected %0d, actual %0d",
                           exp_r.pending_gesture, got.pending_gesture);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
